/* rtl/i2cbs_pkg.sv */
// Shared types and constants for the I2C master bit sequencer.
// No dependencies; imported by i2cbs_step and the top level.
`default_nettype none

package i2cbs_pkg;

  localparam int unsigned OpW     = 4;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned AddrW   = 7;
  localparam int unsigned InDataW  = 24;  // 21 field bits, padded to bytes
  localparam int unsigned OutDataW = 16;  // 15 field bits, padded to bytes

  typedef enum logic [OpW-1:0] {
    OP_NONE      = 4'd0,
    OP_START     = 4'd1,
    OP_REP_START = 4'd2,
    OP_STOP      = 4'd3,
    OP_WR_BYTE   = 4'd4,
    OP_WR_ADDR   = 4'd5,
    OP_RD_BYTE   = 4'd6,
    OP_ACK       = 4'd7,
    OP_NACK      = 4'd8,
    OP_GET_ACK   = 4'd9,
    OP_STATUS    = 4'd10
  } op_e;

  localparam logic [ByteW-1:0] CfgSetupReset = 8'd10;
  localparam logic [ByteW-1:0] WrLastSlot    = 8'd23;
  localparam logic [ByteW-1:0] RdLastSlot    = 8'd15;

  // start command stages
  localparam logic [1:0] StSetup = 2'd0;
  localparam logic [1:0] StSdaLo = 2'd1;
  localparam logic [1:0] StSclLo = 2'd2;

  // write phases within one bit
  localparam logic [1:0] PhData = 2'd0;
  localparam logic [1:0] PhHigh = 2'd1;
  localparam logic [1:0] PhLow  = 2'd2;

  typedef struct packed {
    logic scl;
    logic sda;
    logic oe;
    logic dir_in;
  } lines_t;

  localparam lines_t LinesReset = '{scl: 1'b1, sda: 1'b1, oe: 1'b1, dir_in: 1'b1};

  typedef struct packed {
    op_e              cmd;
    logic [ByteW-1:0] slot;
    logic [1:0]       phase;   // slot mod 3, used by the write commands
    logic [1:0]       stage;   // start command stage
    logic [ByteW-1:0] shreg;
    logic [ByteW-1:0] rxreg;
    lines_t           lines;
    logic             sampled;
  } seq_state_t;

  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] tx_byte;
    logic [AddrW-1:0] address;
    logic             read_write;
    logic             sda_in;
  } seq_in_t;

  typedef struct packed {
    lines_t           lines;
    logic             busy;
    logic             done;
    logic [ByteW-1:0] rx_byte;
    logic             sampled;
  } seq_out_t;

endpackage

`default_nettype wire

/* rtl/i2cbs_step.sv */
// One-slot next-state and result logic of the I2C bit sequencer.
// Purely combinational; uses types and constants from i2cbs_pkg.
`default_nettype none

module i2cbs_step import i2cbs_pkg::*; (
  input  seq_state_t       state_i,
  input  seq_in_t          item_i,
  input  logic [ByteW-1:0] setup_i,
  output seq_state_t       state_o,
  output seq_out_t         res_o
);

  seq_state_t       st;
  logic             busy;
  logic             done;
  logic             release_after;
  logic [ByteW-1:0] setup_eff;
  logic [ByteW-1:0] slot_inc;
  logic             op_valid;

  assign op_valid = (item_i.op != OP_NONE) && (item_i.op <= OP_STATUS);

  always_comb begin
    st            = state_i;
    done          = 1'b0;
    release_after = 1'b0;
    setup_eff     = (setup_i == '0) ? ByteW'(1) : setup_i;
    slot_inc      = state_i.slot + ByteW'(1);

    if ((st.cmd == OP_NONE) && op_valid) begin
      st.cmd   = item_i.op;
      st.slot  = '0;
      st.phase = PhData;
      st.stage = StSetup;
      if (item_i.op == OP_WR_BYTE) begin
        st.shreg = item_i.tx_byte;
      end else if (item_i.op == OP_WR_ADDR) begin
        st.shreg = {item_i.address, item_i.read_write};
      end else if (item_i.op == OP_RD_BYTE) begin
        st.shreg = '0;
      end
      slot_inc = ByteW'(1);
    end

    busy = (st.cmd != OP_NONE);

    unique case (st.cmd)
      OP_START: begin
        if (st.stage == StSetup) begin
          st.lines.dir_in = 1'b0;
          st.slot         = slot_inc;
          if (slot_inc >= setup_eff) st.stage = StSdaLo;
        end else if (st.stage == StSdaLo) begin
          st.lines.sda = 1'b0;
          st.stage     = StSclLo;
        end else begin
          st.lines.scl = 1'b0;
          done         = 1'b1;
        end
      end
      OP_REP_START: begin
        unique case (st.slot)
          8'd0:    st.lines.sda = 1'b1;
          8'd1:    st.lines.scl = 1'b1;
          8'd2:    st.lines.sda = 1'b0;
          default: begin
            st.lines.scl = 1'b0;
            done         = 1'b1;
          end
        endcase
      end
      OP_STOP: begin
        unique case (st.slot)
          8'd0:    st.lines.sda = 1'b0;
          8'd1:    st.lines.scl = 1'b1;
          8'd2:    st.lines.sda = 1'b1;
          default: begin
            st.lines.dir_in = 1'b1;
            done            = 1'b1;
          end
        endcase
      end
      OP_WR_BYTE, OP_WR_ADDR: begin
        if (st.phase == PhData) begin
          st.lines.sda = st.shreg[ByteW-1];
        end else if (st.phase == PhHigh) begin
          st.lines.scl = 1'b1;
        end else begin
          st.lines.scl = 1'b0;
          st.shreg     = {st.shreg[ByteW-2:0], 1'b0};
          if (st.slot >= WrLastSlot) done = 1'b1;
        end
      end
      OP_RD_BYTE: begin
        if (st.slot == '0) begin
          st.lines.dir_in = 1'b1;
          st.lines.oe     = 1'b0;
        end
        if (!st.slot[0]) begin
          st.lines.scl = 1'b1;
          st.shreg     = {st.shreg[ByteW-2:0], item_i.sda_in};
        end else begin
          st.lines.scl = 1'b0;
          if (st.slot >= RdLastSlot) begin
            st.rxreg      = st.shreg;
            done          = 1'b1;
            release_after = 1'b1;
          end
        end
      end
      OP_ACK, OP_NACK: begin
        unique case (st.slot)
          8'd0:    st.lines.sda = (st.cmd == OP_NACK);
          8'd1:    st.lines.scl = 1'b1;
          default: begin
            st.lines.scl = 1'b0;
            done         = 1'b1;
          end
        endcase
      end
      OP_GET_ACK: begin
        unique case (st.slot)
          8'd0:    st.lines.dir_in = 1'b1;
          8'd1: begin
            st.lines.oe  = 1'b0;
            st.lines.scl = 1'b1;
            st.sampled   = item_i.sda_in;
          end
          8'd2:    st.lines.scl = 1'b0;
          default: begin
            st.lines.oe     = 1'b1;
            st.lines.dir_in = 1'b0;
            done            = 1'b1;
          end
        endcase
      end
      OP_STATUS: begin
        if (st.slot == '0) begin
          st.lines.dir_in = 1'b1;
          st.lines.oe     = 1'b0;
          st.sampled      = item_i.sda_in;
        end else if (st.slot >= 8'd2) begin
          st.lines.oe = 1'b1;
          done        = 1'b1;
        end
      end
      default: ;
    endcase

    // result shows pins before the post-command release
    res_o.lines   = st.lines;
    res_o.busy    = busy;
    res_o.done    = done;
    res_o.rx_byte = st.rxreg;
    res_o.sampled = st.sampled;

    if (done) begin
      st.cmd   = OP_NONE;
      st.slot  = '0;
      st.phase = PhData;
      st.stage = StSetup;
      if (release_after) begin
        st.lines.oe     = 1'b1;
        st.lines.dir_in = 1'b0;
      end
    end else if (busy && (st.cmd != OP_START)) begin
      st.slot  = st.slot + ByteW'(1);
      st.phase = (st.phase == PhLow) ? PhData : st.phase + 2'd1;
    end

    state_o = st;
  end

endmodule

`default_nettype wire

/* rtl/i2c_master_bit_sequencer_unit.sv */
// Top level of the I2C master bit sequencer: stream ports, state and result registers.
// Depends on i2cbs_pkg and i2cbs_step.
//
//  channel   | direction | beat contents
//  ----------+-----------+-------------------------------------------------
//  s_axis    | in        | one slot: command and sampled SDA
//  m_axis    | out       | one result per slot: pins, flags, rx byte, bit
//  cfg       | in        | start_setup_slots, write-only
//
// One beat in, one beat out; a beat is taken every cycle while the result
// register is empty or being drained, so throughput is one slot per clock, and
// each result is registered. The slot logic sits between the sequencer state register
// and the result register. Reset idles the sequencer, drives SCL/SDA high with
// OE on and the buffer set to input, and loads a setup count of 10. A stalled
// output holds its beat and blocks new input only while it is not drained.
`default_nettype none

module i2c_master_bit_sequencer_unit import i2cbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ByteW-1:0]    cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [3:0] operation, [11:4] tx_byte, [18:12] address, [19] read_write,
  // [20] sda_in, [23:21] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] scl, [1] sda_out, [2] sda_oe, [3] buffer_dir_in, [4] busy_res,
  // [5] done_res, [13:6] rx_byte, [14] sampled_bit, [15] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam seq_state_t StateReset = '{
    cmd: OP_NONE, slot: '0, phase: PhData, stage: StSetup,
    shreg: '0, rxreg: '0, lines: LinesReset, sampled: 1'b0
  };

  logic [ByteW-1:0] setup_q;
  seq_state_t       state_q, state_d;
  seq_in_t          item;
  seq_out_t         res;
  seq_out_t         res_q;
  logic             out_valid_q;
  logic             in_beat;

  assign item.op         = op_e'(s_axis_tdata[3:0]);
  assign item.tx_byte    = s_axis_tdata[11:4];
  assign item.address    = s_axis_tdata[18:12];
  assign item.read_write = s_axis_tdata[19];
  assign item.sda_in     = s_axis_tdata[20];

  i2cbs_step u_step (
    .state_i (state_q),
    .item_i  (item),
    .setup_i (setup_q),
    .state_o (state_d),
    .res_o   (res)
  );

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_q <= CfgSetupReset;
    end else if (cfg_we_i) begin
      setup_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_beat) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.sampled, res_q.rx_byte, res_q.done, res_q.busy,
                          res_q.lines.dir_in, res_q.lines.oe, res_q.lines.sda,
                          res_q.lines.scl};

endmodule

`default_nettype wire
